// File: hdl/sliding_window_multiset_match_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window multiset matcher
// Concurrent assertion wrappers used by the matcher RTL; they compile to
// nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MULTISET_MATCH_DEFINES_SVH
`define SLIDING_WINDOW_MULTISET_MATCH_DEFINES_SVH

`ifndef ASSERT_OFF

// Invariant that must hold at every clock edge outside reset.
`define SWMM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define SWMM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define SWMM_ASSERT(label, clk, rst, prop, msg)
`define SWMM_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// File: hdl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window multiset matcher package
// Sizes, stream packing widths and command codes used by the matcher RTL.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Largest pattern (and window) length in elements.
  localparam int MAX_PATTERN   = 64;
  localparam int VALUE_BITS    = 32;
  localparam int POSITION_BITS = 20;

  // Pattern entry / ring slot index, and a count that can hold MAX_PATTERN.
  localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_BITS = $clog2(MAX_PATTERN + 1);

  // Ring entry: position, pattern entry index, foreign flag.
  localparam int RING_BITS = POSITION_BITS + IDX_BITS + 1;

  // Stream widths, padded up to whole bytes.
  localparam int S_DATA_BITS = ((VALUE_BITS + POSITION_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((1 + POSITION_BITS + 7) / 8) * 8;
  localparam int CMD_BITS    = 2;

  // Command codes carried in s_tuser.
  localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_DATA    = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd3;

endpackage

// File: hdl/swmm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data; a read of the
// address being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sliding_window_multiset_match.sv
// ----------------------------------------------------------------------------
// Sliding window multiset matcher
// Reports the windows of a data stream whose multiset of values equals a
// loaded pattern multiset (anagram match).
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle on the input stream and returns
// exactly one result beat for every input beat, in the next cycle through an
// output register, so a sustained rate of one item per cycle is kept as long
// as the output side takes its beats. The command in s_tuser selects the
// meaning of a beat: load a pattern element, restart the window, feed a data
// element, or clear pattern and window. Pattern elements are kept as up to
// MAX_PATTERN distinct values, each with a needed count, and the number of
// loaded elements is the window length. Every data element is compared
// against all pattern entries at once; its entry index (or a foreign mark)
// and its position go into a ring memory that holds the window. The read
// port of that memory is always pointed at the oldest element of the window,
// so the element that leaves the window is ready without a lookup. Per-entry
// window counts, the number of entries whose count differs from the needed
// count, and the number of foreign elements are all updated in the same
// cycle. A beat reports matched with the position of the oldest window
// element when it fills the window and the window equals the pattern;
// every other beat reports zero. Loading a pattern element also restarts the
// window. There is no clearing pass after reset: all counters clear at once.
// ----------------------------------------------------------------------------
`include "sliding_window_multiset_match_defines.svh"

module sliding_window_multiset_match (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields from bit 0 up: value, position, zero fill.
  input  logic [swmm_pkg::S_DATA_BITS-1:0] s_tdata,
  // s_tuser fields from bit 0 up: command.
  input  logic [swmm_pkg::CMD_BITS-1:0]    s_tuser,
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata fields from bit 0 up: matched, start_position, zero fill.
  output logic [swmm_pkg::M_DATA_BITS-1:0] m_tdata
);

  import swmm_pkg::*;

  localparam int SUM_BITS = CNT_BITS + 1;

  // Pattern table: values and needed counts are payload, entry count is control.
  logic [VALUE_BITS-1:0] pattern_values [MAX_PATTERN];
  logic [CNT_BITS-1:0]   pattern_need   [MAX_PATTERN];
  logic [CNT_BITS-1:0]   window_counts  [MAX_PATTERN];
  logic [CNT_BITS-1:0]   pattern_entries;
  logic [CNT_BITS-1:0]   pattern_length;
  logic [CNT_BITS-1:0]   window_fill;
  logic [CNT_BITS-1:0]   foreign_count;
  logic [CNT_BITS-1:0]   mismatch_entries;
  logic [IDX_BITS-1:0]   ring_head;

  // Result register.
  logic                     out_matched;
  logic [POSITION_BITS-1:0] out_start;

  // Decoded input beat.
  logic                     accept;
  logic [VALUE_BITS-1:0]    in_value;
  logic [POSITION_BITS-1:0] in_pos;
  logic                     data_go;
  logic                     load_go;
  logic                     restart_go;
  logic                     clear_go;

  // Lookup of the incoming value in the pattern table.
  logic [MAX_PATTERN-1:0] hit;
  logic                   hit_any;
  logic [IDX_BITS-1:0]    hit_idx;

  // Ring memory access.
  logic [SUM_BITS-1:0]  slot_sum;
  logic [IDX_BITS-1:0]  slot;
  logic [IDX_BITS-1:0]  head_inc;
  logic [IDX_BITS-1:0]  head_next;
  logic [RING_BITS-1:0] ring_wr_data;
  logic [RING_BITS-1:0] ring_rd_data;

  // Element leaving the window.
  logic                     full;
  logic                     rem_foreign;
  logic [IDX_BITS-1:0]      rem_idx;
  logic [POSITION_BITS-1:0] rem_pos;
  logic                     rem_hit;
  logic                     add_hit;
  logic                     same_entry;

  // Per-entry comparisons of count against needed count.
  logic [MAX_PATTERN-1:0] eq_now;
  logic [MAX_PATTERN-1:0] eq_up;
  logic [MAX_PATTERN-1:0] eq_down;
  logic                   rem_eq_mid;
  logic                   rem_eq_end;

  logic [CNT_BITS-1:0]      mismatch_mid;
  logic [CNT_BITS-1:0]      mismatch_end;
  logic [CNT_BITS-1:0]      foreign_mid;
  logic [CNT_BITS-1:0]      foreign_end;
  logic [CNT_BITS-1:0]      entries_next;
  logic                     matched_now;
  logic [POSITION_BITS-1:0] start_now;

  // --------------------------------------------------------------------------
  // Handshake and command decode. A beat enters whenever the result register
  // is empty or being emptied in the same cycle.
  // --------------------------------------------------------------------------
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_value = s_tdata[VALUE_BITS-1:0];
  assign in_pos   = s_tdata[VALUE_BITS +: POSITION_BITS];

  assign data_go    = accept && (s_tuser == CMD_DATA) && (pattern_length != '0);
  assign load_go    = accept && (s_tuser == CMD_LOAD) &&
                      (pattern_length < CNT_BITS'(MAX_PATTERN));
  assign restart_go = accept && ((s_tuser == CMD_LOAD) || (s_tuser == CMD_RESTART));
  assign clear_go   = accept && (s_tuser == CMD_CLEAR);

  // --------------------------------------------------------------------------
  // Parallel compare against every valid pattern entry. Values are distinct,
  // so at most one entry hits and the index is an OR of the hit positions.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i] = (CNT_BITS'(i) < pattern_entries) && (pattern_values[i] == in_value);
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_BITS'(i);
      end
    end
  end

  assign hit_any = |hit;

  assign entries_next = (load_go && !hit_any) ? pattern_entries + 1'b1 : pattern_entries;

  // --------------------------------------------------------------------------
  // Ring addressing. The new element goes to head + fill; the head moves on
  // when the window is full. Both wrap at the ring depth.
  // --------------------------------------------------------------------------
  assign slot_sum = SUM_BITS'(ring_head) + SUM_BITS'(window_fill);
  assign slot     = (slot_sum >= SUM_BITS'(MAX_PATTERN)) ?
                    IDX_BITS'(slot_sum - SUM_BITS'(MAX_PATTERN)) : IDX_BITS'(slot_sum);
  assign head_inc = (ring_head == IDX_BITS'(MAX_PATTERN - 1)) ? '0 : ring_head + 1'b1;
  assign full     = (window_fill + 1'b1) >= pattern_length;

  always_comb begin
    head_next = ring_head;
    if (rst || restart_go || clear_go) begin
      head_next = '0;
    end else if (data_go && full) begin
      head_next = head_inc;
    end
  end

  // Each ring entry keeps the pattern entry of the element rather than its
  // value, so the leaving element needs no second table lookup.
  assign ring_wr_data = {!hit_any, hit_idx, in_pos};

  // The read address follows the next head, so the oldest element is on the
  // read data in the cycle that may remove it.
  swmm_ram #(
    .WIDTH (RING_BITS),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk     (clk),
    .wr_en   (data_go),
    .wr_addr (slot),
    .wr_data (ring_wr_data),
    .rd_addr (head_next),
    .rd_data (ring_rd_data)
  );

  // With an empty window the element that enters is also the oldest one.
  always_comb begin
    if (window_fill == '0) begin
      {rem_foreign, rem_idx, rem_pos} = ring_wr_data;
    end else begin
      {rem_foreign, rem_idx, rem_pos} = ring_rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // Count bookkeeping. The match is judged after the new element is counted
  // and before the oldest one is dropped.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq_now[i]  = window_counts[i] == pattern_need[i];
      eq_up[i]   = (window_counts[i] + 1'b1) == pattern_need[i];
      eq_down[i] = (window_counts[i] - 1'b1) == pattern_need[i];
    end
  end

  assign add_hit    = hit_any;
  assign rem_hit    = full && !rem_foreign;
  assign same_entry = add_hit && rem_hit && (rem_idx == hit_idx);
  assign rem_eq_mid = same_entry ? eq_up[rem_idx] : eq_now[rem_idx];
  assign rem_eq_end = same_entry ? eq_now[rem_idx] : eq_down[rem_idx];

  assign mismatch_mid = mismatch_entries + CNT_BITS'(add_hit && eq_now[hit_idx])
                      - CNT_BITS'(add_hit && eq_up[hit_idx]);
  assign mismatch_end = mismatch_mid + CNT_BITS'(rem_hit && rem_eq_mid)
                      - CNT_BITS'(rem_hit && rem_eq_end);
  assign foreign_mid  = foreign_count + CNT_BITS'(!hit_any);
  assign foreign_end  = foreign_mid
                      - CNT_BITS'(full && rem_foreign && (foreign_mid != '0));

  assign matched_now = data_go && full && (mismatch_mid == '0) && (foreign_mid == '0);
  assign start_now   = matched_now ? rem_pos : '0;

  // --------------------------------------------------------------------------
  // Control state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      pattern_entries  <= '0;
      pattern_length   <= '0;
      window_fill      <= '0;
      foreign_count    <= '0;
      mismatch_entries <= '0;
      ring_head        <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_counts[i] <= '0;
      end
    end else if (restart_go) begin
      pattern_entries  <= entries_next;
      pattern_length   <= load_go ? pattern_length + 1'b1 : pattern_length;
      window_fill      <= '0;
      foreign_count    <= '0;
      mismatch_entries <= entries_next;
      ring_head        <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_counts[i] <= '0;
      end
    end else if (data_go) begin
      window_fill      <= full ? window_fill : window_fill + 1'b1;
      foreign_count    <= foreign_end;
      mismatch_entries <= mismatch_end;
      ring_head        <= head_next;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_counts[i] <= window_counts[i] + CNT_BITS'(hit[i])
                          - CNT_BITS'(rem_hit && (rem_idx == IDX_BITS'(i)));
      end
    end
  end

  // Pattern payload: only entries below pattern_entries are ever read. Each
  // entry updates itself from its own hit, and a new value lands in the
  // entry just past the last one in use.
  always_ff @(posedge clk) begin
    if (load_go) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (hit[i]) begin
          pattern_need[i] <= pattern_need[i] + 1'b1;
        end else if (!hit_any && (pattern_entries == CNT_BITS'(i))) begin
          pattern_values[i] <= in_value;
          pattern_need[i]   <= CNT_BITS'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_matched <= matched_now;
      out_start   <= start_now;
    end
  end

  assign m_tdata = M_DATA_BITS'({out_start, out_matched});

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `SWMM_ASSERT(a_fill_below_length, clk, rst, (window_fill == '0) || (window_fill < pattern_length), "window fill reached the pattern length")
  `SWMM_ASSERT(a_entries_le_length, clk, rst, pattern_entries <= pattern_length, "more pattern entries than loaded elements")
  `SWMM_ASSERT(a_mismatch_le_entries, clk, rst, mismatch_entries <= pattern_entries, "mismatch count exceeds pattern entries")
  `SWMM_ASSERT(a_start_zero, clk, rst, !m_tvalid || out_matched || (out_start == '0), "start position set on an unmatched result")
  `SWMM_ASSERT_NEXT(a_empty_no_match, clk, rst, accept && (pattern_length == '0), !out_matched, "match reported with an empty pattern")

endmodule
